>>> hdl/tcrf_pkg.sv
// ----------------------------------------------------------------------------
// tcrf_pkg
// types, codes and hash helper for the connection tracking rate filter
// ----------------------------------------------------------------------------
package tcrf_pkg;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  frame_kind;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [5:0]  flag_bits;
      logic [63:0] timestamp_ns;
      logic        allow_value;
   } req_type;

   typedef struct packed {
      logic       verdict;
      logic [3:0] cause;
      logic [3:0] track_state;
   } rsp_type;

   localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

   localparam logic [5:0] F_FIN = 6'h01;
   localparam logic [5:0] F_SYN = 6'h02;
   localparam logic [5:0] F_RST = 6'h04;
   localparam logic [5:0] F_PSH = 6'h08;
   localparam logic [5:0] F_ACK = 6'h10;
   localparam logic [5:0] F_URG = 6'h20;

   localparam logic [3:0] ST_NEW          = 4'd0;
   localparam logic [3:0] ST_SYN_SENT     = 4'd1;
   localparam logic [3:0] ST_SYN_RECEIVED = 4'd2;
   localparam logic [3:0] ST_ESTABLISHED  = 4'd3;
   localparam logic [3:0] ST_FIN_WAIT_1   = 4'd4;
   localparam logic [3:0] ST_FIN_WAIT_2   = 4'd5;
   localparam logic [3:0] ST_TIME_WAIT    = 4'd6;
   localparam logic [3:0] ST_CLOSE        = 4'd7;
   localparam logic [3:0] ST_CLOSE_WAIT   = 4'd8;
   localparam logic [3:0] ST_LAST_ACK     = 4'd9;
   localparam logic [3:0] ST_RELATED      = 4'd10;
   localparam logic [3:0] ST_INVALID      = 4'd11;

   localparam logic [3:0] CAUSE_OK      = 4'd0;
   localparam logic [3:0] CAUSE_WHITE   = 4'd1;
   localparam logic [3:0] CAUSE_MALFORM = 4'd2;
   localparam logic [3:0] CAUSE_NOT_TCP = 4'd3;
   localparam logic [3:0] CAUSE_FLAGS   = 4'd4;
   localparam logic [3:0] CAUSE_NO_SYN  = 4'd5;
   localparam logic [3:0] CAUSE_RATE    = 4'd6;
   localparam logic [3:0] CAUSE_INVALID = 4'd7;
   localparam logic [3:0] CAUSE_WRITE   = 4'd8;

   localparam logic [2:0] KIND_SHORT   = 3'd0;
   localparam logic [2:0] KIND_NOT_IP  = 3'd1;
   localparam logic [2:0] KIND_NOT_TCP = 3'd3;
   localparam logic [2:0] KIND_TCP     = 3'd5;

   localparam logic [2:0] CSR_SYN    = 3'd0;
   localparam logic [2:0] CSR_SYNACK = 3'd1;
   localparam logic [2:0] CSR_FIN    = 3'd2;
   localparam logic [2:0] CSR_RST    = 3'd3;
   localparam logic [2:0] CSR_WINDOW = 3'd4;

   localparam logic [1:0] CLS_NEW  = 2'd0;
   localparam logic [1:0] CLS_HAND = 2'd1;
   localparam logic [1:0] CLS_FIN  = 2'd2;
   localparam logic [1:0] CLS_RST  = 2'd3;

   // status of a finished lookup passed to the rate stage
   typedef struct packed {
      logic       go;
      logic       limited;
      logic [1:0] cls;
      logic [3:0] st;
   } conn_result_type;

   function automatic logic bad_flags(input logic [5:0] f);
      logic b;
      b = (f == 6'd0);
      b = b | ((f & (F_FIN | F_SYN)) == (F_FIN | F_SYN));
      b = b | ((f & (F_SYN | F_RST)) == (F_SYN | F_RST));
      b = b | ((f & (F_FIN | F_RST)) == (F_FIN | F_RST));
      b = b | ((f & (F_ACK | F_FIN)) == F_FIN);
      b = b | ((f & (F_ACK | F_URG)) == F_URG);
      b = b | ((f & (F_ACK | F_PSH)) == F_PSH);
      b = b | ((f & (F_FIN | F_PSH | F_URG)) == (F_FIN | F_PSH | F_URG));
      return b;
   endfunction

   function automatic logic [3:0] next_state(input logic [3:0] s, input logic [5:0] f);
      logic [3:0] n;
      n = s;
      case (s)
         ST_NEW:          if (f[1]) n = ST_SYN_SENT;
         ST_SYN_SENT:     if (f[1] && f[4]) n = ST_SYN_RECEIVED;
         ST_SYN_RECEIVED: if (f[4]) n = ST_ESTABLISHED;
         ST_ESTABLISHED: begin
            if (f[0]) n = ST_FIN_WAIT_1;
            else if (f[2]) n = ST_CLOSE;
         end
         ST_FIN_WAIT_1: begin
            if (f[4]) n = ST_FIN_WAIT_2;
            else if (f[0]) n = ST_TIME_WAIT;
         end
         ST_FIN_WAIT_2:   if (f[0]) n = ST_TIME_WAIT;
         ST_TIME_WAIT:    if (f[4]) n = ST_CLOSE;
         ST_CLOSE_WAIT:   if (f[0]) n = ST_LAST_ACK;
         ST_LAST_ACK:     if (f[4]) n = ST_CLOSE;
         default:         n = ST_INVALID;
      endcase
      return n;
   endfunction

endpackage

>>> hdl/tcrf_hash.sv
// ----------------------------------------------------------------------------
// tcrf_hash
// pipelined multiplicative hash: upper product word modulo a table size
// ----------------------------------------------------------------------------
module tcrf_hash
   import tcrf_pkg::*;
#(
   parameter int SIZE = 4096,
   parameter int AW   = 12
) (
   input  logic          clock,
   input  logic [63:0]   key,
   output logic [AW-1:0] slot
);

   // reciprocal of the table size scaled by 2^(32+AW), fits 33 bits
   localparam logic [63:0] RECIP_FULL = (64'd1 << (32 + AW)) / SIZE;
   localparam logic [32:0] RECIP      = RECIP_FULL[32:0];
   localparam logic [AW:0] SIZE_W     = SIZE[AW:0];

   // product bits 63:32 from 32x32 partial products, one stage each
   logic [63:0]     lo_lo_in;
   logic [31:0]     lo_lo_ff;
   logic [31:0]     lo_hi_ff, lo_hi_in, hi_lo_ff, hi_lo_in;
   logic [31:0]     upper_ff, upper_in;
   logic [64:0]     prod_ff, prod_in, quot_full;
   logic [AW:0]     low_ff, quot, rem, fix;
   logic [2*AW+1:0] qs;
   logic [AW-1:0]   slot_ff, slot_in;

   assign lo_lo_in = {32'd0, key[31:0]} * {32'd0, GOLDEN[31:0]};
   assign lo_hi_in = key[31:0] * GOLDEN[63:32];
   assign hi_lo_in = key[63:32] * GOLDEN[31:0];
   assign upper_in = lo_lo_ff + lo_hi_ff + hi_lo_ff;

   // quotient estimate is exact or one low, so one subtract corrects it
   assign prod_in   = {33'd0, upper_ff} * {32'd0, RECIP};
   assign quot_full = prod_ff >> (32 + AW);
   assign quot      = quot_full[AW:0];
   assign qs        = {{(AW+1){1'b0}}, quot} * {{(AW+1){1'b0}}, SIZE_W};
   assign rem       = low_ff - qs[AW:0];
   assign fix       = (rem >= SIZE_W) ? rem - SIZE_W : rem;
   assign slot_in   = fix[AW-1:0];

   always_ff @(posedge clock) begin
      lo_lo_ff <= lo_lo_in[63:32];
      lo_hi_ff <= lo_hi_in;
      hi_lo_ff <= hi_lo_in;
      upper_ff <= upper_in;
      prod_ff  <= prod_in;
      low_ff   <= upper_ff[AW:0];
      slot_ff  <= slot_in;
   end

   assign slot = slot_ff;

endmodule

>>> hdl/tcrf_rate.sv
// ----------------------------------------------------------------------------
// tcrf_rate
// per-source windowed packet counter held in one synchronous memory
// ----------------------------------------------------------------------------
module tcrf_rate
   import tcrf_pkg::*;
#(
   parameter int RW = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear_en,
   input  logic [RW-1:0] clear_addr,
   input  logic          rd_en,
   input  logic [RW-1:0] rd_addr,
   input  logic          chk_en,
   input  logic [31:0]   src,
   input  logic [63:0]   now,
   input  logic [31:0]   limit,
   input  logic [39:0]   window,
   output logic          pass
);

   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
      logic [31:0] count;
      logic [63:0] start;
   } rate_entry_type;

   rate_entry_type mem [1 << RW];
   rate_entry_type rd_ff, wr_data;
   logic [RW-1:0] addr_ff, addr_in;
   logic [31:0] cnt;
   logic [63:0] st, age;

   assign addr_in = rd_en ? rd_addr : addr_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= mem[rd_addr];
      addr_ff <= addr_in;
      if (clear_en) mem[clear_addr] <= '0;
      else if (chk_en) mem[addr_ff] <= wr_data;
   end

   always_comb begin
      cnt = rd_ff.count;
      st  = rd_ff.start;
      if (!rd_ff.valid || rd_ff.addr != src) begin
         cnt = 32'd0;
         st  = now;
      end
      age = now - st;
      if (age >= {24'd0, window}) begin
         cnt = 32'd0;
         st  = now;
      end
      pass          = cnt < limit;
      wr_data.valid = 1'b1;
      wr_data.addr  = src;
      wr_data.count = pass ? cnt + 32'd1 : cnt;
      wr_data.start = st;
   end

   a_no_clear_chk: assert property (@(posedge clock) disable iff (reset)
      !(clear_en && chk_en)) else $error("rate check during clear");

endmodule

>>> hdl/tcp_conntrack_rate_filter.sv
// ----------------------------------------------------------------------------
// tcp_conntrack_rate_filter
// tcp state tracking firewall with whitelist and per-source rate limits
// ----------------------------------------------------------------------------
// channel  ports                      direction  handshake
// req      req_payload                in         start & !busy
// rsp      rsp_payload                out        rsp_valid, one cycle
// csr      csr_we csr_index csr_data  in         csr_we
//
// each transaction runs from start to rsp_valid through four hash
// stages, then the whitelist and connection memory reads, then the
// rate memory read-modify-write. busy stays high until the result.
// after reset a clearing pass over every whitelist, connection and
// rate memory entry runs with busy high; csr writes are taken during
// it. results cannot be stalled.
// ----------------------------------------------------------------------------
module tcp_conntrack_rate_filter
   import tcrf_pkg::*;
#(
   parameter int CONN_ENTRIES   = 4096,
   parameter int SOURCE_ENTRIES = 4096,
   parameter int ALLOW_ENTRIES  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [39:0] csr_data
);

   localparam int CW = $clog2(CONN_ENTRIES);
   localparam int SW = $clog2(SOURCE_ENTRIES);
   localparam int AW = $clog2(ALLOW_ENTRIES);
   localparam int RW = SW + 2;
   localparam int RN = 1 << RW;
   localparam int CLRN = (RN > CONN_ENTRIES) ?
                         ((RN > ALLOW_ENTRIES) ? RN : ALLOW_ENTRIES)
                         : ((CONN_ENTRIES > ALLOW_ENTRIES) ? CONN_ENTRIES : ALLOW_ENTRIES);
   localparam int KW = $clog2(CLRN + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CONN  = 3'd4;
   localparam logic [2:0] S_RATE  = 3'd5;

   logic [31:0] syn_lim_ff, synack_lim_ff, fin_lim_ff, rst_lim_ff;
   logic [39:0] window_ff;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    wait_ff, wait_in;
   logic [KW-1:0] clr_ff, clr_in;
   req_type       req_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   conn_result_type cres_ff, cres_in;

   logic [AW-1:0] a_slot;
   logic [CW-1:0] c_slot;
   logic [SW-1:0] s_slot;

   tcrf_hash #(.SIZE(ALLOW_ENTRIES), .AW(AW)) u_hash_allow (
      .clock(clock), .key({32'd0, req_ff.source_addr}), .slot(a_slot));
   tcrf_hash #(.SIZE(CONN_ENTRIES), .AW(CW)) u_hash_conn (
      .clock(clock), .key({req_ff.source_addr, req_ff.dest_addr}), .slot(c_slot));
   tcrf_hash #(.SIZE(SOURCE_ENTRIES), .AW(SW)) u_hash_src (
      .clock(clock), .key({32'd0, req_ff.source_addr}), .slot(s_slot));

   // whitelist and connection memories, cleared after reset
   logic [32:0] allow_mem [1 << AW];
   logic [68:0] conn_mem  [1 << CW];
   logic [32:0] allow_rd_ff;
   logic [68:0] conn_rd_ff;
   logic [AW-1:0] a_slot_ff;
   logic [CW-1:0] c_slot_ff;
   logic [SW-1:0] s_slot_ff;
   logic          clearing;
   logic          allow_we, conn_we;
   logic [32:0]   allow_wd;
   logic [68:0]   conn_wd;

   assign clearing = (state_ff == S_CLEAR);

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         allow_rd_ff <= allow_mem[a_slot];
         conn_rd_ff  <= conn_mem[c_slot];
         a_slot_ff   <= a_slot;
         c_slot_ff   <= c_slot;
         s_slot_ff   <= s_slot;
      end
      if (clearing) begin
         if ({{(32-KW){1'b0}}, clr_ff} < ALLOW_ENTRIES) allow_mem[clr_ff[AW-1:0]] <= '0;
         if ({{(32-KW){1'b0}}, clr_ff} < CONN_ENTRIES) conn_mem[clr_ff[CW-1:0]] <= '0;
      end else begin
         if (allow_we) allow_mem[a_slot_ff] <= allow_wd;
         if (conn_we) conn_mem[c_slot_ff] <= conn_wd;
      end
   end

   logic       allow_hit, conn_hit;
   logic [3:0] nst;

   assign allow_hit = allow_rd_ff[32] && allow_rd_ff[31:0] == req_ff.source_addr;
   assign conn_hit  = conn_rd_ff[68] &&
                      conn_rd_ff[67:4] == {req_ff.source_addr, req_ff.dest_addr};
   assign nst       = next_state(conn_rd_ff[3:0], req_ff.flag_bits);

   always_comb begin
      rsp_in   = rsp_ff;
      cres_in  = cres_ff;
      allow_we = 1'b0;
      allow_wd = {1'b1, req_ff.source_addr};
      conn_we  = 1'b0;
      conn_wd  = {1'b1, req_ff.source_addr, req_ff.dest_addr, ST_NEW};
      if (state_ff == S_CONN) begin
         rsp_in  = '{verdict: 1'b1, cause: CAUSE_OK, track_state: ST_NEW};
         cres_in = '{go: 1'b0, limited: 1'b0, cls: CLS_NEW, st: ST_NEW};
         if (req_ff.opcode) begin
            rsp_in.cause = CAUSE_WRITE;
            if (req_ff.allow_value) begin
               allow_we = 1'b1;
            end else if (allow_hit) begin
               allow_we = 1'b1;
               allow_wd = '0;
            end
         end else if (req_ff.frame_kind == KIND_SHORT || req_ff.frame_kind == KIND_NOT_IP
                      || req_ff.frame_kind == KIND_NOT_TCP) begin
            rsp_in.cause = CAUSE_NOT_TCP;
         end else if (req_ff.frame_kind != KIND_TCP) begin
            rsp_in.verdict = 1'b0;
            rsp_in.cause   = CAUSE_MALFORM;
         end else if (allow_hit) begin
            rsp_in.cause = CAUSE_WHITE;
         end else if (bad_flags(req_ff.flag_bits)) begin
            rsp_in.verdict = 1'b0;
            rsp_in.cause   = CAUSE_FLAGS;
         end else begin
            if (conn_hit) begin
               cres_in.st = nst;
               conn_we    = 1'b1;
               conn_wd[3:0] = nst;
               cres_in.go = 1'b1;
            end else if (req_ff.flag_bits[1]) begin
               conn_we    = 1'b1;
               cres_in.go = 1'b1;
            end else begin
               rsp_in.verdict = 1'b0;
               rsp_in.cause   = CAUSE_NO_SYN;
            end
            rsp_in.track_state = cres_in.st;
            cres_in.limited    = 1'b1;
            case (cres_in.st)
               ST_NEW:                               cres_in.cls = CLS_NEW;
               ST_SYN_SENT, ST_SYN_RECEIVED:         cres_in.cls = CLS_HAND;
               ST_FIN_WAIT_1, ST_FIN_WAIT_2,
               ST_TIME_WAIT:                         cres_in.cls = CLS_FIN;
               ST_CLOSE, ST_CLOSE_WAIT, ST_LAST_ACK: cres_in.cls = CLS_RST;
               ST_ESTABLISHED, ST_RELATED:           cres_in.limited = 1'b0;
               default: begin
                  cres_in.limited = 1'b0;
                  if (cres_in.go) begin
                     rsp_in.verdict = 1'b0;
                     rsp_in.cause   = CAUSE_INVALID;
                  end
               end
            endcase
         end
      end
   end

   // rate stage: memory read issued in S_CONN, check in S_RATE
   logic [31:0] lim;
   logic        rate_pass;
   logic        rate_rd, rate_chk;

   assign rate_rd  = (state_ff == S_CONN);
   assign rate_chk = (state_ff == S_RATE) && cres_ff.go && cres_ff.limited;

   always_comb begin
      case (cres_ff.cls)
         CLS_NEW:  lim = syn_lim_ff;
         CLS_HAND: lim = synack_lim_ff;
         CLS_FIN:  lim = fin_lim_ff;
         default:  lim = rst_lim_ff;
      endcase
   end

   tcrf_rate #(.RW(RW)) u_rate (
      .clock(clock), .reset(reset),
      .clear_en(clearing), .clear_addr(clr_ff[RW-1:0]),
      .rd_en(rate_rd), .rd_addr({cres_in.cls, s_slot_ff}),
      .chk_en(rate_chk), .src(req_ff.source_addr), .now(req_ff.timestamp_ns),
      .limit(lim), .window(window_ff), .pass(rate_pass));

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if ({{(32-KW){1'b0}}, clr_ff} == CLRN - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_HASH;
               wait_in  = 3'd0;
            end
         end
         S_HASH: begin
            wait_in = wait_ff + 3'd1;
            if (wait_ff == 3'd3) state_in = S_READ;
         end
         S_READ: state_in = S_CONN;
         S_CONN: state_in = S_RATE;
         S_RATE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         wait_ff       <= 3'd0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         syn_lim_ff    <= 32'd1;
         synack_lim_ff <= 32'd60;
         fin_lim_ff    <= 32'd1;
         rst_lim_ff    <= 32'd1;
         window_ff     <= 40'd1000000000;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SYN:    syn_lim_ff    <= csr_data[31:0];
               CSR_SYNACK: synack_lim_ff <= csr_data[31:0];
               CSR_FIN:    fin_lim_ff    <= csr_data[31:0];
               CSR_RST:    rst_lim_ff    <= csr_data[31:0];
               CSR_WINDOW: window_ff     <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) req_ff <= req_payload;
      cres_ff <= cres_in;
      if (state_ff == S_RATE) begin
         if (rate_chk && !rate_pass) begin
            rsp_ff.verdict <= 1'b0;
            rsp_ff.cause   <= CAUSE_RATE;
         end
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_after_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_RATE) else $error("result without rate stage");
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid_in) else $error("result during clear");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in |-> busy) else $error("result while idle");

endmodule
